>>> hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_SAME_CYCLE(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("same-cycle check failed");

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT_CYCLE(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/stg_pkg.sv
// types, constants and the quarter-wave sine table of the tone generator
package stg_pkg;

   // phase and table geometry
   localparam int TABLE_BITS = 10;
   localparam int PHASE_BITS = 32;
   localparam int QBITS      = TABLE_BITS - 2;
   localparam int QN         = 1 << QBITS;

   // field widths
   localparam int KIND_W   = 2;
   localparam int STEP_W   = 32;
   localparam int DUR_W    = 20;
   localparam int VOL_W    = 16;
   localparam int SAMPLE_W = 16;
   localparam int RATE_W   = 18;
   localparam int COUNT_W  = 28;
   localparam int TAB_W    = 15;

   localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(16000);
   localparam logic [VOL_W-1:0]   GAIN_ONE   = VOL_W'(32768);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
   localparam int MS_PER_S = 1000;

   // rate split into rate / 1000 and rate % 1000 by reciprocal multiply
   localparam int RATE_RECIP_W     = 19;
   localparam logic [RATE_RECIP_W-1:0] RATE_RECIP = RATE_RECIP_W'(268436);
   localparam int RATE_RECIP_SHIFT = 28;
   localparam int RATE_PROD_W      = RATE_W + RATE_RECIP_W;
   localparam int A_W              = RATE_PROD_W - RATE_RECIP_SHIFT;
   localparam int B_W              = 10;

   // count = a * dur + (b * dur) / 1000
   localparam int AD_W              = A_W + DUR_W;
   localparam int BD_W              = B_W + DUR_W;
   localparam int MILLI_RECIP_W     = 31;
   localparam logic [MILLI_RECIP_W-1:0] MILLI_RECIP = MILLI_RECIP_W'(1099511628);
   localparam int MILLI_RECIP_SHIFT = 40;
   localparam int Q2_W              = BD_W + MILLI_RECIP_W;
   localparam int QUO_W             = Q2_W - MILLI_RECIP_SHIFT;
   localparam int SUM_W             = AD_W + 1;

   // sample scaling
   localparam int PROD_W = TAB_W + VOL_W;

   // intake hold after a rate write
   localparam int SETTLE_W = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(2);

   typedef enum logic [KIND_W-1:0] {
      KIND_START = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

   // per-request control carried down the pipe
   typedef struct packed {
      logic start_ok;
      logic active;
      logic neg;
      logic top;
      logic playing;
      logic tone_end;
   } stg_ctl_type;

   typedef logic [TAB_W-1:0] qtab_type [QN];

   // taylor series of sin to the x^11 term, q30 fixed point
   function automatic logic [TAB_W-1:0] sine_entry(int unsigned i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x    = (64'd1686629713 * 64'(i)) >> QBITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      v    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      return (v > 64'd32767) ? TAB_W'(32767) : v[TAB_W-1:0];
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int unsigned i = 0; i < QN; i++) begin
         t[i] = sine_entry(i);
      end
      return t;
   endfunction

   localparam qtab_type         QTAB     = build_qtab();
   localparam logic [TAB_W-1:0] QTAB_TOP = sine_entry(QN);

endpackage

>>> hw/rtl/sine_tone_generator_top.sv
// sine tone generator top level: phase accumulator, sine rom and sample pipe
//
// Direct digital synthesis tone generator. A start request loads a phase step,
// a Q15 gain (saturated at 1.0) and a sample count of rate * duration_ms / 1000;
// each tick request then returns one sine sample while samples remain, and a
// stop request ends the tone. Every request gives exactly one response, which
// passes through stage 1, stage 2 and the response register. Ticks, stops and
// rejected starts are taken one per cycle while the response side does not
// stall. An accepted start holds the intake until its sample count has gone
// through the reciprocal multipliers that replace the divide by 1000. A write
// of the rate register holds the intake while rate / 1000 and rate % 1000 are
// refreshed; the same hold follows reset. The phase carries over from tone to
// tone. Backpressure on the response port stalls the pipe.
module sine_tone_generator_top import stg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [STEP_W-1:0]          req_tone_step,
   input  logic [DUR_W-1:0]           req_duration_ms,
   input  logic [VOL_W-1:0]           req_volume,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_accepted,
   output logic                       rsp_playing,
   output logic                       rsp_tone_end,
   input  logic                       csr_wr_en,
   input  logic [RATE_W-1:0]          csr_wr_data
);

   // rate register and its split by 1000
   logic [RATE_W-1:0]      rate_ff;
   logic [A_W-1:0]         rate_a_ff;
   logic [B_W-1:0]         rate_b_ff;
   logic [SETTLE_W-1:0]    settle_ff;
   logic [RATE_PROD_W-1:0] rate_prod;
   logic [RATE_W-1:0]      rate_a_k;

   // tone state
   logic [PHASE_BITS-1:0]  phase_ff;
   logic [PHASE_BITS-1:0]  step_ff;
   logic [VOL_W-1:0]       gain_ff;
   logic [COUNT_W-1:0]     left_ff;

   // pipe stage 1
   logic                   p1_valid_ff;
   stg_ctl_type            p1_ctl_ff;
   logic [VOL_W-1:0]       p1_gain_ff;
   logic [AD_W-1:0]        p1_ad_ff;
   logic [BD_W-1:0]        p1_bd_ff;
   logic [TAB_W-1:0]       rom_q_ff;

   // pipe stage 2
   logic                   p2_valid_ff;
   stg_ctl_type            p2_ctl_ff;
   logic [PROD_W-1:0]      p2_prod_ff;
   logic [AD_W-1:0]        p2_ad_ff;
   logic [Q2_W-1:0]        p2_q_ff;

   // response register
   logic                   out_valid_ff;
   logic [SAMPLE_W-1:0]    out_sample_ff;
   logic                   out_accepted_ff;
   logic                   out_playing_ff;
   logic                   out_tone_end_ff;

   // intake decode
   logic                   adv;
   logic                   start_busy;
   logic                   accept;
   logic [PHASE_BITS-1:0]  step_ext;
   logic [TABLE_BITS-1:0]  tab_idx;
   logic [QBITS-1:0]       tab_pos;
   logic [QBITS-1:0]       rom_addr;
   logic [COUNT_W-1:0]     left_dec;
   stg_ctl_type            ctl_in;
   logic                   tick_in;
   logic                   stop_in;
   logic [VOL_W-1:0]       gain_sat;

   // stage 1 and 2 datapath
   logic [TAB_W-1:0]       tab_val;
   logic [QUO_W-1:0]       quo;
   logic [SUM_W-1:0]       count_sum;
   logic [COUNT_W-1:0]     count;
   logic [SAMPLE_W-1:0]    mag;
   logic [SAMPLE_W-1:0]    sample_calc;
   logic                   playing_out;

   // ---------------------------------------------------------------
   // handshake: the whole pipe moves when the response slot frees up;
   // an accepted start blocks intake until its count lands
   // ---------------------------------------------------------------
   assign adv        = !out_valid_ff || rsp_ready;
   assign start_busy = (p1_valid_ff && p1_ctl_ff.start_ok) ||
                       (p2_valid_ff && p2_ctl_ff.start_ok);
   assign req_ready  = adv && !start_busy && (settle_ff == '0);
   assign accept     = req_valid && req_ready;

   // ---------------------------------------------------------------
   // rate register: a = rate / 1000 is registered from the rate register and
   // b = rate % 1000 from the rate register and a; intake waits for both
   // ---------------------------------------------------------------
   assign rate_prod = RATE_PROD_W'(rate_ff) * RATE_PROD_W'(RATE_RECIP);
   assign rate_a_k  = RATE_W'(rate_a_ff) * RATE_W'(MS_PER_S);

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= RATE_RESET;
         settle_ff <= SETTLE_CYCLES;
      end else if (csr_wr_en) begin
         rate_ff   <= csr_wr_data;
         settle_ff <= SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - SETTLE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rate_a_ff <= rate_prod[RATE_PROD_W-1 -: A_W];
      rate_b_ff <= B_W'(rate_ff - rate_a_k);
   end

   // ---------------------------------------------------------------
   // intake decode: phase step, tick bookkeeping and rom address
   // ---------------------------------------------------------------
   assign step_ext = PHASE_BITS'(req_tone_step);
   assign tab_idx  = phase_ff[PHASE_BITS-1 -: TABLE_BITS];
   assign tab_pos  = tab_idx[QBITS-1:0];
   // odd quadrants run the quarter table backwards
   assign rom_addr = tab_idx[QBITS] ? (~tab_pos + QBITS'(1)) : tab_pos;
   assign left_dec = left_ff - COUNT_W'(1);
   assign gain_sat = (req_volume > GAIN_ONE) ? GAIN_ONE : req_volume;

   always_comb begin
      ctl_in          = '0;
      tick_in         = 1'b0;
      stop_in         = 1'b0;
      ctl_in.playing  = (left_ff != '0);
      ctl_in.neg      = tab_idx[TABLE_BITS-1];
      ctl_in.top      = tab_idx[QBITS] && (tab_pos == '0);
      unique case (kind_type'(req_kind))
         KIND_START: begin
            ctl_in.start_ok = (step_ext != '0) && (req_duration_ms != '0);
         end
         KIND_TICK: begin
            if (left_ff != '0) begin
               tick_in         = 1'b1;
               ctl_in.active   = 1'b1;
               ctl_in.playing  = (left_dec != '0);
               ctl_in.tone_end = (left_dec == '0);
            end
         end
         KIND_STOP: begin
            stop_in        = 1'b1;
            ctl_in.playing = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------
   // tone state: ticks and stops act at intake, a start's count lands at
   // the end of the pipe while intake is held
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         step_ff  <= '0;
         gain_ff  <= '0;
         left_ff  <= '0;
      end else begin
         if (accept && tick_in) begin
            phase_ff <= phase_ff + step_ff;
            left_ff  <= left_dec;
         end
         if (accept && stop_in) begin
            left_ff <= '0;
         end
         if (accept && ctl_in.start_ok) begin
            step_ff <= step_ext;
            gain_ff <= gain_sat;
         end
         if (adv && p2_valid_ff && p2_ctl_ff.start_ok) begin
            left_ff <= count;
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 1: sine rom read, count partial products
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rom_q_ff   <= QTAB[rom_addr];
         p1_ctl_ff  <= ctl_in;
         p1_gain_ff <= gain_ff;
         p1_ad_ff   <= AD_W'(rate_a_ff) * AD_W'(req_duration_ms);
         p1_bd_ff   <= BD_W'(rate_b_ff) * BD_W'(req_duration_ms);
      end
   end

   // ---------------------------------------------------------------
   // stage 2: gain multiply, reciprocal multiply for the remainder part
   // ---------------------------------------------------------------
   // the peak of an odd quadrant sits one past the rom
   assign tab_val = p1_ctl_ff.top ? QTAB_TOP : rom_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_ctl_ff  <= p1_ctl_ff;
         p2_prod_ff <= PROD_W'(tab_val) * PROD_W'(p1_gain_ff);
         p2_ad_ff   <= p1_ad_ff;
         p2_q_ff    <= Q2_W'(p1_bd_ff) * Q2_W'(MILLI_RECIP);
      end
   end

   // ---------------------------------------------------------------
   // stage 3: count sum with saturation, sample sign, response register
   // ---------------------------------------------------------------
   assign quo       = p2_q_ff[Q2_W-1 -: QUO_W];
   assign count_sum = SUM_W'(p2_ad_ff) + SUM_W'(quo);
   assign count     = (count_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : count_sum[COUNT_W-1:0];

   assign mag         = p2_prod_ff[PROD_W-1 -: SAMPLE_W];
   assign sample_calc = !p2_ctl_ff.active ? '0 :
                        p2_ctl_ff.neg     ? (~mag + SAMPLE_W'(1)) : mag;
   assign playing_out = p2_ctl_ff.start_ok ? (count != '0) : p2_ctl_ff.playing;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_sample_ff   <= sample_calc;
         out_accepted_ff <= p2_ctl_ff.start_ok;
         out_playing_ff  <= playing_out;
         out_tone_end_ff <= p2_ctl_ff.tone_end;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_sample   = signed'(out_sample_ff);
   assign rsp_accepted = out_accepted_ff;
   assign rsp_playing  = out_playing_ff;
   assign rsp_tone_end = out_tone_end_ff;

endmodule

>>> hw/rtl/stg_checker.sv
// port-level checker for the tone generator and its bind
`include "assert_macros.svh"

module stg_checker import stg_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample,
   input logic                       rsp_accepted,
   input logic                       rsp_playing,
   input logic                       rsp_tone_end,
   input logic                       csr_wr_en
);

   logic sample_nonzero;
   logic end_clean;

   assign sample_nonzero = (rsp_sample != '0);
   assign end_clean      = !rsp_playing && !rsp_accepted;

   // a stalled response stays offered
   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a sample only comes from a tick, never from a start
   `ASSERT_SAME_CYCLE(a_sample_not_start, clock, reset, rsp_valid && sample_nonzero, !rsp_accepted)

   // the last sample of a tone leaves nothing playing
   `ASSERT_SAME_CYCLE(a_end_idle, clock, reset, rsp_valid && rsp_tone_end, end_clean)

   // intake waits while the rate split refreshes
   `ASSERT_NEXT_CYCLE(a_rate_settle, clock, reset, csr_wr_en, !req_ready)

endmodule

bind sine_tone_generator_top stg_checker u_stg_checker (.*);
